[src/q4k_pkg.sv]
// Shared types, constants and float helpers for the block dequantizer.
`timescale 1ns / 1ps
package q4k_pkg;
    localparam int unsigned ELEM_LIMIT_W = 9;
    localparam logic [8:0] ELEM_LIMIT_RESET = 9'd256;
    localparam int unsigned SCALE_BYTES = 8;

    typedef enum logic [1:0] {
        OP_SCALE_BYTE = 2'd0,
        OP_BLOCK_SCALE = 2'd1,
        OP_BLOCK_MIN = 2'd2,
        OP_QUANT_BYTE = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_SUB,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic do_mul1;
        logic do_mul2;
        logic do_sub;
    } q4k_cmd_t;

    typedef struct packed {
        logic has_elem0;
        logic has_elem1;
    } q4k_status_t;

    localparam logic [31:0] FP32_QNAN = 32'h7FC00000;

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [31:0] r;
        logic [7:0] ex;
        begin
            ex = {3'd0, h[14:10]} + 8'd112;
            if (h[14:10] == 5'd0)
                r = {h[15], 31'd0};
            else if (h[14:10] == 5'h1F)
                r = {h[15], 8'hFF, (h[9:0] != 10'd0), 22'd0};
            else
                r = {h[15], ex, h[9:0], 13'd0};
            return r;
        end
    endfunction

    // Exact small integer 0..15 to single.
    function automatic logic [31:0] nib_to_single(input logic [3:0] n);
        logic [31:0] r;
        begin
            if (n[3])
                r = {1'b0, 8'd130, n[2:0], 20'd0};
            else if (n[2])
                r = {1'b0, 8'd129, n[1:0], 21'd0};
            else if (n[1])
                r = {1'b0, 8'd128, n[0], 22'd0};
            else if (n[0])
                r = {1'b0, 8'd127, 23'd0};
            else
                r = 32'd0;
            return r;
        end
    endfunction

    // Round-to-nearest-even single multiply, subnormals handled.
    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        logic sa;
        logic sb;
        logic sr;
        logic [7:0] ea;
        logic [7:0] eb;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [47:0] p;
        logic [5:0] lz;
        logic [5:0] i;
        logic signed [10:0] e;
        logic [49:0] w;
        logic [24:0] m;
        logic g;
        logic st;
        logic [31:0] r;
        logic a_nan;
        logic b_nan;
        logic a_inf;
        logic b_inf;
        logic a_zero;
        logic b_zero;
        logic [5:0] sh;
        begin
            sa = a[31];
            sb = b[31];
            sr = sa ^ sb;
            ea = a[30:23];
            eb = b[30:23];
            a_nan = (ea == 8'hFF) && (a[22:0] != 23'd0);
            b_nan = (eb == 8'hFF) && (b[22:0] != 23'd0);
            a_inf = (ea == 8'hFF) && (a[22:0] == 23'd0);
            b_inf = (eb == 8'hFF) && (b[22:0] == 23'd0);
            a_zero = (a[30:0] == 31'd0);
            b_zero = (b[30:0] == 31'd0);
            ma = {(ea != 8'd0), a[22:0]};
            mb = {(eb != 8'd0), b[22:0]};
            p = ma * mb;
            lz = 6'd48;
            for (i = 6'd0; i < 6'd48; i = i + 6'd1)
                if (p[i[5:0]])
                    lz = 6'd47 - i;
            // value = p * 2^(ea'+eb'-254-46); normalized top at bit 47
            e = $signed({3'd0, (ea == 8'd0) ? 8'd1 : ea})
                + $signed({3'd0, (eb == 8'd0) ? 8'd1 : eb}) - 11'sd126
                - $signed({5'd0, lz});
            w = {p, 2'b00} << lz;
            if (e < 11'sd1)
            begin
                sh = (e < -11'sd30) ? 6'd31 : 6'(11'sd1 - e);
                w = (w >> sh) | {49'd0, |(w & ~({50{1'b1}} << sh))};
                e = 11'sd0;
            end
            m = {1'b0, w[49:26]};
            g = w[25];
            st = |w[24:0];
            if (g && (st || m[0]))
                m = m + 25'd1;
            if (m[24])
            begin
                m = m >> 1;
                e = e + 11'sd1;
            end
            else if ((e == 11'sd0) && m[23])
                e = 11'sd1;
            if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
                r = FP32_QNAN;
            else if (a_inf || b_inf || (e >= 11'sd255))
                r = {sr, 8'hFF, 23'd0};
            else if (a_zero || b_zero)
                r = {sr, 31'd0};
            else
                r = {sr, e[7:0], m[22:0]};
            return r;
        end
    endfunction

    // Round-to-nearest-even single subtract a - b.
    function automatic logic [31:0] fsub(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] t;
        logic [31:0] r;
        logic [7:0] ex;
        logic [7:0] ey;
        logic [7:0] d;
        logic [27:0] mx;
        logic [27:0] my;
        logic [27:0] mm;
        logic [28:0] s;
        logic [4:0] lz;
        logic [5:0] i;
        logic signed [9:0] e;
        logic [24:0] m;
        logic x_nan;
        logic y_nan;
        begin
            x = a;
            y = {~b[31], b[30:0]};
            x_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
            y_nan = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
            if (x[30:0] < y[30:0])
            begin
                t = x;
                x = y;
                y = t;
            end
            ex = x[30:23];
            ey = y[30:23];
            mx = {1'b0, (ex != 8'd0), x[22:0], 3'd0};
            my = {1'b0, (ey != 8'd0), y[22:0], 3'd0};
            d = ((ex == 8'd0) ? 8'd1 : ex) - ((ey == 8'd0) ? 8'd1 : ey);
            if (d > 8'd27)
                mm = {27'd0, |my};
            else
                mm = (my >> d) | {27'd0, |(my & ~({28{1'b1}} << d))};
            if (x[31] == y[31])
                s = {1'b0, mx} + {1'b0, mm};
            else
                s = {1'b0, mx} - {1'b0, mm};
            e = $signed({2'd0, (ex == 8'd0) ? 8'd1 : ex});
            if (s[27])
            begin
                s = {1'b0, s[28:1]} | {28'd0, s[0]};
                e = e + 10'sd1;
            end
            lz = 5'd0;
            for (i = 6'd0; i < 6'd27; i = i + 6'd1)
                if (s[i[4:0]])
                    lz = 5'(6'd26 - i);
            if ($signed({5'd0, lz}) >= e)
                lz = 5'(e - 10'sd1);
            s = s << lz;
            e = e - $signed({5'd0, lz});
            if (!s[26])
                e = 10'sd0;
            m = {1'b0, s[26:3]};
            if (s[2] && ((|s[1:0]) || m[0]))
                m = m + 25'd1;
            if (m[24])
            begin
                m = m >> 1;
                e = e + 10'sd1;
            end
            else if ((e == 10'sd0) && m[23])
                e = 10'sd1;
            if (x_nan || y_nan)
                r = FP32_QNAN;
            else if (ex == 8'hFF)
                r = ((ey == 8'hFF) && (x[31] != y[31])) ? FP32_QNAN : x;
            else if (s == 29'd0)
                r = {x[31] & y[31], 31'd0};
            else if (e >= 10'sd255)
                r = {x[31], 8'hFF, 23'd0};
            else
                r = {x[31], e[7:0], m[22:0]};
            return r;
        end
    endfunction
endpackage

[src/q4k_if.sv]
// Valid/ready stream interface with a generic payload.
`timescale 1ns / 1ps
interface q4k_if #(parameter type payload_t = logic) ();
    logic valid;
    logic ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[src/q4k_ctrl.sv]
// Sequencer for header loads and per-element float steps.
`timescale 1ns / 1ps
module q4k_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic [1:0] in_op,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  q4k_pkg::q4k_status_t status,
    output q4k_pkg::q4k_cmd_t cmd,
    output logic elem_sel,
    output logic last_flag
);
    import q4k_pkg::*;
    state_t state_reg;
    state_t state_next;
    logic sel_reg;
    logic sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next = sel_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (in_op == OP_QUANT_BYTE)
                    begin
                        sel_next = 1'b0;
                        state_next = ST_MUL1;
                    end
                end
            end
            ST_MUL1:
            begin
                // start the selected element, or drop the byte if it does not survive
                if (sel_reg ? status.has_elem1 : status.has_elem0)
                begin
                    cmd.do_mul1 = 1'b1;
                    state_next = ST_MUL2;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_MUL2:
            begin
                cmd.do_mul2 = 1'b1;
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                cmd.do_sub = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (!sel_reg && status.has_elem1)
                    begin
                        sel_next = 1'b1;
                        state_next = ST_MUL1;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign elem_sel = sel_reg;
    assign last_flag = sel_reg || !status.has_elem1;
endmodule

[src/q4k_datapath.sv]
// Header storage, element decode and registered float steps.
`timescale 1ns / 1ps
module q4k_datapath (
    input  logic clk,
    input  logic rst_n,
    input  q4k_pkg::q4k_cmd_t cmd,
    input  logic elem_sel,
    input  logic [1:0] in_op,
    input  logic [7:0] in_index,
    input  logic [15:0] in_data,
    input  logic [q4k_pkg::ELEM_LIMIT_W-1:0] limit,
    output q4k_pkg::q4k_status_t status,
    output logic [7:0] element_index,
    output logic [31:0] value_bits
);
    import q4k_pkg::*;
    logic [7:0] smb_reg [SCALE_BYTES];
    logic [15:0] dh_reg;
    logic [15:0] mh_reg;
    logic [7:0] bidx_reg;
    logic [7:0] bval_reg;
    logic [31:0] ds_reg;
    logic [31:0] off_reg;
    logic [31:0] prod_reg;
    logic [31:0] res_reg;
    logic [3:0] q_reg;
    logic [8:0] e0;
    logic [8:0] e1;
    logic [7:0] ecur;
    logic [2:0] grp;
    logic [7:0] sb;
    logic [7:0] mb;
    logic [3:0] s_nib;
    logic [3:0] m_nib;
    logic [31:0] r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SCALE_BYTES; k++)
                smb_reg[k] <= 8'd0;
            dh_reg <= 16'd0;
            mh_reg <= 16'd0;
        end
        else if (cmd.load_item)
        begin
            case (opcode_t'(in_op))
                OP_SCALE_BYTE:
                    if (in_index < 8'(SCALE_BYTES))
                        smb_reg[in_index[2:0]] <= in_data[7:0];
                OP_BLOCK_SCALE: dh_reg <= in_data;
                OP_BLOCK_MIN: mh_reg <= in_data;
                default: ;
            endcase
        end
    end

    assign e0 = {bidx_reg, 1'b0};
    assign e1 = {bidx_reg, 1'b1};
    assign status.has_elem0 = !bidx_reg[7] && (e0 < limit);
    assign status.has_elem1 = !bidx_reg[7] && (e1 < limit);

    assign ecur = {bidx_reg[6:0], elem_sel};
    assign grp = ecur[7:5];
    assign sb = smb_reg[{1'b0, grp[2:1]}];
    assign mb = smb_reg[{1'b1, grp[2:1]}];
    assign s_nib = grp[0] ? sb[7:4] : sb[3:0];
    assign m_nib = grp[0] ? mb[7:4] : mb[3:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            bidx_reg <= in_index;
            bval_reg <= in_data[7:0];
        end
        if (cmd.do_mul1)
        begin
            ds_reg <= fmul(half_to_single(dh_reg), nib_to_single(s_nib));
            q_reg <= elem_sel ? bval_reg[3:0] : bval_reg[7:4];
        end
        if (cmd.do_mul2)
        begin
            prod_reg <= fmul(ds_reg, nib_to_single(q_reg));
            off_reg <= fmul(half_to_single(mh_reg), nib_to_single(m_nib));
        end
        if (cmd.do_sub)
            res_reg <= r;
    end

    always_comb
    begin
        r = fsub(prod_reg, off_reg);
        if ((r[30:23] == 8'hFF) && (r[22:0] != 23'd0))
            r = FP32_QNAN;
    end

    assign element_index = ecur;
    assign value_bits = res_reg;
endmodule

[src/q4k_block_dequantizer.sv]
// Top level of the 4-bit block dequantizer.
// Header items are loaded in ST_IDLE; a quant byte is loaded there and each
// emitted element runs MUL1, MUL2, SUB and OUT (two float multiply stages,
// one subtract, one output state held until out_ready); a byte is dropped in
// MUL1 if neither element survives the limit; a result is valid in OUT.
// Reset (rst_n low, asynchronous) clears scales to zero and limit to 256.
`timescale 1ns / 1ps
module q4k_block_dequantizer (
    input  logic clk,
    input  logic rst_n,
    q4k_if.sink in_ch,
    q4k_if.source out_ch,
    input  logic cfg_we,
    input  logic [q4k_pkg::ELEM_LIMIT_W-1:0] cfg_wdata
);
    import q4k_pkg::*;
    logic [ELEM_LIMIT_W-1:0] limit_reg;
    q4k_cmd_t cmd;
    q4k_status_t status;
    logic elem_sel;
    logic last_flag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= ELEM_LIMIT_RESET;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    q4k_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_op(in_ch.payload.opcode),
        .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .status(status), .cmd(cmd), .elem_sel(elem_sel), .last_flag(last_flag)
    );

    q4k_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .elem_sel(elem_sel),
        .in_op(in_ch.payload.opcode), .in_index(in_ch.payload.byte_index),
        .in_data(in_ch.payload.data_value), .limit(limit_reg),
        .status(status),
        .element_index(out_ch.payload.element_index),
        .value_bits(out_ch.payload.value_bits)
    );

    assign out_ch.payload.last_of_run = last_flag;

    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready) else $error("input taken during output");
    a_elem_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> ({1'b0, out_ch.payload.element_index} < limit_reg))
        else $error("element past limit");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_item, cmd.do_mul1, cmd.do_mul2, cmd.do_sub}))
        else $error("overlapping commands");
endmodule

[test/tb_q4k_block_dequantizer.sv]
// Self-checking testbench for the 4-bit block dequantizer: random blocks against a predictor.
`timescale 1ns / 1ps
module tb_q4k_block_dequantizer;
    import q4k_pkg::*;

    typedef struct packed {
        opcode_t opcode;
        logic [7:0] byte_index;
        logic [15:0] data_value;
    } quant_item_t;

    typedef struct packed {
        logic [7:0] element_index;
        logic [31:0] value_bits;
        logic last_of_run;
    } weight_t;

    // Values are held as integers in units of 2^-24; every product is exact there.
    class dequant_predictor;
        logic [7:0] scale_min[SCALE_BYTES];
        logic [15:0] d_half;
        logic [15:0] dmin_half;
        int unsigned limit;
        weight_t expected_weights[$];
        int errors;

        function new();
            foreach (scale_min[i])
                scale_min[i] = 8'd0;
            d_half = 16'd0;
            dmin_half = 16'd0;
            limit = 256;
            errors = 0;
        endfunction

        function void set_limit(logic [8:0] v);
            limit = (v > 9'd256) ? 256 : v;
        endfunction

        function longint unsigned half_fixed(logic [15:0] h);
            if (h[14:10] == 5'd0)
                return 0;
            return longint'({1'b1, h[9:0]}) << (h[14:10] - 1);
        endfunction

        function logic [31:0] fixed_to_single(logic neg, longint unsigned a);
            int p;
            int sh;
            longint unsigned mant;
            longint unsigned rem;
            longint unsigned halfv;
            logic [7:0] ex;
            p = 63;
            while (!a[p])
                p--;
            if (p <= 23)
                mant = a << (23 - p);
            else
            begin
                sh = p - 23;
                mant = a >> sh;
                rem = a & ((64'd1 << sh) - 1);
                halfv = 64'd1 << (sh - 1);
                if (rem > halfv || (rem == halfv && mant[0]))
                    mant++;
                if (mant[24])
                begin
                    mant = mant >> 1;
                    p++;
                end
            end
            ex = p + 103;
            return {neg, ex, mant[22:0]};
        endfunction

        function logic [31:0] weight_value(int e, logic [3:0] q);
            int g;
            logic [7:0] sb;
            logic [7:0] mb;
            logic [3:0] s;
            logic [3:0] m;
            logic d_inf;
            logic d_nan;
            logic n_inf;
            logic n_nan;
            logic p_inf;
            logic o_inf;
            longint unsigned pm;
            longint unsigned om;
            longint signed diff;
            g = e / 32;
            sb = scale_min[g / 2];
            mb = scale_min[4 + g / 2];
            s = g[0] ? sb[7:4] : sb[3:0];
            m = g[0] ? mb[7:4] : mb[3:0];
            d_inf = d_half[14:10] == 5'h1F && d_half[9:0] == 10'd0;
            d_nan = d_half[14:10] == 5'h1F && d_half[9:0] != 10'd0;
            n_inf = dmin_half[14:10] == 5'h1F && dmin_half[9:0] == 10'd0;
            n_nan = dmin_half[14:10] == 5'h1F && dmin_half[9:0] != 10'd0;
            if (d_nan || n_nan)
                return FP32_QNAN;
            // infinity times zero
            if ((d_inf && (s == 0 || q == 0)) || (n_inf && m == 0))
                return FP32_QNAN;
            p_inf = d_inf;
            o_inf = n_inf;
            if (p_inf && o_inf)
                return (d_half[15] == dmin_half[15]) ? FP32_QNAN : {d_half[15], 8'hFF, 23'd0};
            if (p_inf)
                return {d_half[15], 8'hFF, 23'd0};
            if (o_inf)
                return {~dmin_half[15], 8'hFF, 23'd0};
            pm = half_fixed(d_half) * s * q;
            om = half_fixed(dmin_half) * m;
            diff = (d_half[15] ? -longint'(pm) : longint'(pm))
                - (dmin_half[15] ? -longint'(om) : longint'(om));
            if (diff == 0)
                return {(pm == 0 && d_half[15] && om == 0 && !dmin_half[15]), 31'd0};
            if (diff < 0)
                return fixed_to_single(1'b1, longint'(-diff));
            return fixed_to_single(1'b0, diff);
        endfunction

        function void note_input(quant_item_t it);
            int e;
            int n;
            weight_t w;
            case (it.opcode)
                OP_SCALE_BYTE:
                    if (it.byte_index < SCALE_BYTES)
                        scale_min[it.byte_index] = it.data_value[7:0];
                OP_BLOCK_SCALE: d_half = it.data_value;
                OP_BLOCK_MIN: dmin_half = it.data_value;
                default:
                begin
                    n = 0;
                    for (int k = 0; k < 2; k++)
                    begin
                        e = 2 * it.byte_index + k;
                        if (e < 256 && e < limit)
                        begin
                            w.element_index = e[7:0];
                            w.value_bits = weight_value(e, k == 0 ? it.data_value[7:4]
                                                                  : it.data_value[3:0]);
                            w.last_of_run = 1'b0;
                            expected_weights.push_back(w);
                            n++;
                        end
                    end
                    if (n > 0)
                        expected_weights[$].last_of_run = 1'b1;
                end
            endcase
        endfunction

        function void check_result(weight_t r);
            weight_t x;
            if (expected_weights.size() == 0)
            begin
                $error("unexpected weight: index %0d value %h", r.element_index, r.value_bits);
                errors++;
                return;
            end
            x = expected_weights.pop_front();
            if (r.element_index !== x.element_index)
            begin
                $error("element_index: expected %0d, got %0d", x.element_index, r.element_index);
                errors++;
            end
            if (r.value_bits !== x.value_bits)
            begin
                $error("value_bits: expected %h, got %h", x.value_bits, r.value_bits);
                errors++;
            end
            if (r.last_of_run !== x.last_of_run)
            begin
                $error("last_of_run: expected %b, got %b", x.last_of_run, r.last_of_run);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [ELEM_LIMIT_W-1:0] cfg_wdata;
    logic tx_burst;
    logic rx_burst;
    int weights_seen;

    q4k_if #(.payload_t(quant_item_t)) in_ch ();
    q4k_if #(.payload_t(weight_t)) out_ch ();

    dequant_predictor pred;

    q4k_block_dequantizer dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #2 clk = ~clk;

    function automatic int pick_gap(logic burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    task automatic send(opcode_t op, logic [7:0] idx, logic [15:0] val);
        quant_item_t it;
        int gap;
        it.opcode = op;
        it.byte_index = idx;
        it.data_value = val;
        gap = pick_gap(tx_burst);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= it;
        // ready is sampled at the edge itself, before the block moves on
        @(posedge clk iff in_ch.ready);
        pred.note_input(it);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pred.expected_weights.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(logic [8:0] v);
        drain();
        // a dropped element may still be in flight
        repeat (20) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        pred.set_limit(v);
    endtask

    function automatic logic [15:0] pick_half();
        if ($urandom_range(0, 9) < 8)
            return {1'($urandom), 5'($urandom_range(1, 30)), 10'($urandom)};
        return 16'($urandom);
    endfunction

    task automatic send_block(int quants);
        int order[8];
        tx_burst = ($urandom_range(0, 3) == 0);
        foreach (order[i])
            order[i] = i;
        order.shuffle();
        foreach (order[i])
            send(OP_SCALE_BYTE, 8'(order[i]), 16'($urandom));
        send(OP_BLOCK_SCALE, 8'($urandom_range(0, 143)), pick_half());
        send(OP_BLOCK_MIN, 8'($urandom_range(0, 143)), pick_half());
        repeat (quants)
        begin
            if ($urandom_range(0, 9) == 0)
                send(opcode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 143)),
                     16'($urandom));
            else
                send(OP_QUANT_BYTE, 8'($urandom_range(0, 143)), 16'($urandom));
        end
    endtask

    // Receiver: random stalls, one long hold-off to back up the pipeline.
    initial
    begin
        int stall;
        logic held;
        stall = 0;
        held = 1'b0;
        weights_seen = 0;
        out_ch.ready = 1'b0;
        rx_burst = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && weights_seen >= 100)
            begin
                held = 1'b1;
                stall = 300;
            end
            else if (stall == 0)
            begin
                if ($urandom_range(0, 63) == 0)
                    rx_burst = ~rx_burst;
                stall = pick_gap(rx_burst);
            end
            out_ch.ready <= (stall == 0);
            if (stall > 0)
                stall--;
            @(posedge clk);
        end
    end

    // Check each output transaction with the values present at the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            pred.check_result(out_ch.payload);
            weights_seen++;
        end
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic [8:0] limits[6];
        pred = new();
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        tx_burst = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset state, scale picking, ignored writes, fp16 corner cases.
        send(OP_QUANT_BYTE, 8'd0, 16'h00A5);
        send(OP_SCALE_BYTE, 8'd0, 16'hAB21);
        send(OP_SCALE_BYTE, 8'd1, 16'h43);
        send(OP_SCALE_BYTE, 8'd4, 16'hFF0F);
        send(OP_SCALE_BYTE, 8'd5, 16'h5A);
        send(OP_SCALE_BYTE, 8'd8, 16'hFFFF);
        send(OP_SCALE_BYTE, 8'd143, 16'h77);
        send(OP_BLOCK_SCALE, 8'd0, 16'h3C00);
        send(OP_BLOCK_MIN, 8'd0, 16'h3800);
        send(OP_QUANT_BYTE, 8'd0, 16'hFF0F);
        send(OP_QUANT_BYTE, 8'd16, 16'h00F0);
        send(OP_QUANT_BYTE, 8'd127, 16'hFFFF);
        send(OP_QUANT_BYTE, 8'd128, 16'h0011);
        send(OP_QUANT_BYTE, 8'd143, 16'hFFFF);
        send(OP_BLOCK_SCALE, 8'd0, 16'h8000);
        send(OP_BLOCK_MIN, 8'd0, 16'h0001);
        send(OP_QUANT_BYTE, 8'd20, 16'h0012);
        send(OP_BLOCK_SCALE, 8'd0, 16'h7C00);
        send(OP_BLOCK_MIN, 8'd0, 16'h7C00);
        send(OP_QUANT_BYTE, 8'd40, 16'h0F10);
        send(OP_BLOCK_SCALE, 8'd0, 16'h7E01);
        send(OP_QUANT_BYTE, 8'd60, 16'h0033);
        send(OP_BLOCK_SCALE, 8'd0, 16'h7BFF);
        send(OP_BLOCK_MIN, 8'd0, 16'hFBFF);
        send(OP_QUANT_BYTE, 8'd100, 16'h00FF);

        limits[0] = 9'd256;
        limits[1] = 9'd0;
        limits[2] = 9'd1;
        limits[3] = 9'd511;
        limits[4] = 9'd255;
        limits[5] = 9'($urandom_range(2, 254));
        foreach (limits[p])
        begin
            write_limit(limits[p]);
            for (int b = 0; b < 3; b++)
            begin
                send_block(12);
                // let the whole block come out once before going on
                if (p == 0 && b == 1)
                    drain();
            end
        end

        drain();
        repeat (30) @(posedge clk);
        if (pred.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

[files.f]
src/q4k_pkg.sv
src/q4k_if.sv
src/q4k_ctrl.sv
src/q4k_datapath.sv
src/q4k_block_dequantizer.sv
test/tb_q4k_block_dequantizer.sv
